// ----- hdl/mrlc_pkg.sv -----
// Shared types, constants and helper functions of the modem response line classifier.
package mrlc_pkg;

    localparam int unsigned LINE_STORE  = 32;
    localparam int unsigned CNT_W       = $clog2(LINE_STORE + 1);
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_FILL = 8'hF0;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [1:0] KIND_NUMERIC = 2'd0;
    localparam logic [1:0] KIND_INFO    = 2'd1;
    localparam logic [1:0] KIND_REPLY   = 2'd2;
    localparam logic [1:0] KIND_PROMPT  = 2'd3;

    localparam logic [4:0] FLAG_NONE     = 5'h00;
    localparam logic [4:0] FLAG_ERROR    = 5'h01;
    localparam logic [4:0] FLAG_SAVED    = 5'h02;
    localparam logic [4:0] FLAG_BANNER   = 5'h04;
    localparam logic [4:0] FLAG_CONTINUE = 5'h08;
    localparam logic [4:0] FLAG_TIME     = 5'h10;

    // keywords, left-justified and zero padded to the longest one
    localparam int unsigned KW_MAX = 23;
    localparam logic [KW_MAX*8-1:0] KW_ERROR    = {"ERROR", 144'h0};
    localparam logic [KW_MAX*8-1:0] KW_CONTINUE = {"CONTINUE", 120'h0};
    localparam logic [KW_MAX*8-1:0] KW_SAVED    = {"SAVED", 144'h0};
    localparam logic [KW_MAX*8-1:0] KW_BANNER   = "Devserver - version 1.0";
    localparam logic [KW_MAX*8-1:0] KW_TIME     = {"<time>", 136'h0};

    localparam logic [CNT_W-1:0] KW_ERROR_LEN    = CNT_W'(5);
    localparam logic [CNT_W-1:0] KW_CONTINUE_LEN = CNT_W'(8);
    localparam logic [CNT_W-1:0] KW_SAVED_LEN    = CNT_W'(5);
    localparam logic [CNT_W-1:0] KW_BANNER_LEN   = CNT_W'(23);
    localparam logic [CNT_W-1:0] KW_TIME_LEN     = CNT_W'(6);

    // date/time fields: year, month, day, hour, minute, second
    localparam int unsigned NFIELD = 6;
    localparam int unsigned FIELD_OFS [NFIELD] = '{6, 11, 14, 17, 20, 23};
    localparam logic [13:0] YEAR_CAP  = 14'd9999;
    localparam logic [13:0] SMALL_CAP = 14'd99;

    typedef enum logic [1:0] {
        OP_STORE  = 2'd0,
        OP_CR     = 2'd1,
        OP_LF     = 2'd2,
        OP_PROMPT = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic        act;
        logic [13:0] val;
    } t_fld;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // true when byte b matches keyword kw at position pos inside its length
    function automatic logic kw_hit(input logic [KW_MAX*8-1:0] kw,
                                    input logic [CNT_W-1:0] len,
                                    input logic [CNT_W-1:0] pos,
                                    input logic [7:0] b);
        logic [7:0] ch;
        ch = CH_NUL;
        for (int i = 0; i < KW_MAX; i++) begin
            if (CNT_W'(i) == pos) begin
                ch = kw[(KW_MAX-1-i)*8 +: 8];
            end
        end
        return (pos < len) && (ch == b);
    endfunction

    // one step of a saturating decimal field parse starting at offset ofs
    function automatic t_fld fld_step(input t_fld cur,
                                      input logic [CNT_W-1:0] pos,
                                      input logic [CNT_W-1:0] ofs,
                                      input logic [7:0] b,
                                      input logic [13:0] cap);
        t_fld        nxt;
        logic [16:0] acc;
        nxt = cur;
        acc = ((pos == ofs) ? 17'd0 : 17'(cur.val) * 17'd10) + 17'(b[3:0]);
        if ((pos == ofs) || ((pos > ofs) && cur.act)) begin
            if (is_digit(b)) begin
                nxt.act = 1'b1;
                nxt.val = (acc > 17'(cap)) ? cap : acc[13:0];
            end else begin
                nxt.act = 1'b0;
            end
        end
        return nxt;
    endfunction

endpackage

// ----- hdl/mrlc_in_if.sv -----
// Receive byte channel.
interface mrlc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- hdl/mrlc_out_if.sv -----
// Classified line result channel.
interface mrlc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [9:0]  code_onehot;
    logic [7:0]  line_length;
    logic [4:0]  reply_flags;
    logic [13:0] year_value;
    logic [6:0]  month_value;
    logic [6:0]  day_value;
    logic [6:0]  hour_value;
    logic [6:0]  minute_value;
    logic [6:0]  second_value;
    logic        overflowed;

    modport source (output valid, output kind, output code_onehot, output line_length,
                    output reply_flags, output year_value, output month_value,
                    output day_value, output hour_value, output minute_value,
                    output second_value, output overflowed, input ready);
    modport sink   (input valid, input kind, input code_onehot, input line_length,
                    input reply_flags, input year_value, input month_value,
                    input day_value, input hour_value, input minute_value,
                    input second_value, input overflowed, output ready);
endinterface

// ----- hdl/mrlc_front.sv -----
// Front end: accepts receive bytes and turns them into line commands.
module mrlc_front import mrlc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mrlc_in_if.sink   i_rx,
    input  logic      i_q_full,
    output logic      o_push,
    output t_cmd      o_cmd
);

    logic r_empty;
    logic n_empty;
    logic keep;
    logic take;

    assign i_rx.ready = !i_q_full;
    assign take       = i_rx.valid && !i_q_full;

    always_comb begin
        n_empty    = r_empty;
        keep       = 1'b0;
        o_cmd.op   = OP_STORE;
        o_cmd.data = i_rx.rx_byte;
        priority if (i_rx.rx_byte == CH_CR && !r_empty) begin
            o_cmd.op = OP_CR;
            keep     = 1'b1;
            n_empty  = 1'b1;
        end else if (i_rx.rx_byte == CH_LF && !r_empty) begin
            o_cmd.op = OP_LF;
            keep     = 1'b1;
            n_empty  = 1'b1;
        end else if (i_rx.rx_byte == CH_GT && r_empty) begin
            o_cmd.op = OP_PROMPT;
            keep     = 1'b1;
        end else if (i_rx.rx_byte != CH_NUL && i_rx.rx_byte != CH_FILL
                     && i_rx.rx_byte != CH_CR && i_rx.rx_byte != CH_LF) begin
            o_cmd.op = OP_STORE;
            keep     = 1'b1;
            n_empty  = 1'b0;
        end else begin
            // ignored byte or line end on an empty line
            keep = 1'b0;
        end
    end

    assign o_push = take && keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty <= 1'b1;
        end else if (take) begin
            r_empty <= n_empty;
        end
    end

endmodule

// ----- hdl/mrlc_queue.sv -----
// Short command queue between front and back end.
module mrlc_queue import mrlc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_mem[i] <= '0;
            end
        end else if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

endmodule

// ----- hdl/mrlc_back.sv -----
// Back end: line state, keyword match, field parse and result register.
module mrlc_back import mrlc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    mrlc_out_if.source o_res
);

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic [7:0]       r_first, n_first;
    logic             r_m_err, n_m_err;
    logic             r_m_cont, n_m_cont;
    logic             r_m_saved, n_m_saved;
    logic             r_m_banner, n_m_banner;
    logic             r_m_time, n_m_time;
    logic             r_fact [NFIELD];
    logic             n_fact [NFIELD];
    logic [13:0]      r_year, n_year;
    logic [6:0]       r_tval [1:NFIELD-1];
    logic [6:0]       n_tval [1:NFIELD-1];

    logic        r_valid;
    logic [1:0]  r_kind;
    logic [9:0]  r_onehot;
    logic [7:0]  r_len;
    logic [4:0]  r_flags;
    logic [13:0] r_o_year;
    logic [6:0]  r_o_tval [1:NFIELD-1];
    logic        r_o_ovf;

    logic        emits;
    logic        out_load;
    logic [7:0]  b;
    logic [1:0]  res_kind;
    logic [9:0]  res_onehot;
    logic [7:0]  res_len;
    logic [4:0]  res_flags;
    logic        res_ovf;
    logic [8:0]  cnt9;
    t_fld        cur;
    t_fld        nxt;

    assign b     = i_cmd.data;
    assign emits = (i_cmd.op != OP_STORE);
    assign o_pop = i_q_valid && (!emits || !r_valid || o_res.ready);
    assign out_load = o_pop && emits;
    assign cnt9  = 9'(r_count);

    // line state update
    always_comb begin
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_first    = r_first;
        n_m_err    = r_m_err;
        n_m_cont   = r_m_cont;
        n_m_saved  = r_m_saved;
        n_m_banner = r_m_banner;
        n_m_time   = r_m_time;
        n_year     = r_year;
        n_fact     = r_fact;
        n_tval     = r_tval;
        cur        = '0;
        nxt        = '0;
        if (o_pop) begin
            unique case (i_cmd.op)
                OP_STORE: begin
                    if (r_count < CNT_W'(LINE_STORE)) begin
                        n_count = r_count + CNT_W'(1);
                        if (r_count == '0) begin
                            n_first = b;
                        end
                        n_m_err    = r_m_err && kw_hit(KW_ERROR, KW_ERROR_LEN, r_count, b);
                        n_m_cont   = r_m_cont
                                     && kw_hit(KW_CONTINUE, KW_CONTINUE_LEN, r_count, b);
                        n_m_saved  = r_m_saved && kw_hit(KW_SAVED, KW_SAVED_LEN, r_count, b);
                        n_m_banner = r_m_banner
                                     && kw_hit(KW_BANNER, KW_BANNER_LEN, r_count, b);
                        n_m_time   = r_m_time && ((r_count >= KW_TIME_LEN)
                                     || kw_hit(KW_TIME, KW_TIME_LEN, r_count, b));
                        cur.act   = r_fact[0];
                        cur.val   = r_year;
                        nxt       = fld_step(cur, r_count, CNT_W'(FIELD_OFS[0]), b, YEAR_CAP);
                        n_fact[0] = nxt.act;
                        n_year    = nxt.val;
                        for (int i = 1; i < NFIELD; i++) begin
                            cur.act   = r_fact[i];
                            cur.val   = 14'(r_tval[i]);
                            nxt       = fld_step(cur, r_count, CNT_W'(FIELD_OFS[i]), b,
                                                 SMALL_CAP);
                            n_fact[i] = nxt.act;
                            n_tval[i] = nxt.val[6:0];
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                OP_CR, OP_LF: begin
                    n_count    = '0;
                    n_ovf      = 1'b0;
                    n_m_err    = 1'b1;
                    n_m_cont   = 1'b1;
                    n_m_saved  = 1'b1;
                    n_m_banner = 1'b1;
                    n_m_time   = 1'b1;
                    n_year     = '0;
                    for (int i = 0; i < NFIELD; i++) begin
                        n_fact[i] = 1'b0;
                    end
                    for (int i = 1; i < NFIELD; i++) begin
                        n_tval[i] = '0;
                    end
                end
                OP_PROMPT: begin
                end
            endcase
        end
    end

    // result of the command at the queue head
    always_comb begin
        res_kind   = KIND_NUMERIC;
        res_onehot = '0;
        res_len    = (cnt9 > 9'd255) ? 8'hFF : cnt9[7:0];
        res_flags  = FLAG_NONE;
        res_ovf    = r_ovf;
        unique case (i_cmd.op)
            OP_CR: begin
                if (r_count == CNT_W'(1)) begin
                    res_kind   = KIND_NUMERIC;
                    res_onehot = is_digit(r_first) ? (10'd1 << r_first[3:0]) : 10'd1;
                end else begin
                    res_kind = KIND_INFO;
                end
            end
            OP_LF: begin
                res_kind = KIND_REPLY;
                priority if (r_m_err && r_count == KW_ERROR_LEN) begin
                    res_flags = FLAG_ERROR;
                end else if (r_m_cont && r_count == KW_CONTINUE_LEN) begin
                    res_flags = FLAG_CONTINUE;
                end else if (r_m_saved && r_count == KW_SAVED_LEN) begin
                    res_flags = FLAG_SAVED;
                end else if (r_m_banner && r_count == KW_BANNER_LEN) begin
                    res_flags = FLAG_BANNER;
                end else if (r_m_time && r_count >= KW_TIME_LEN) begin
                    res_flags = FLAG_TIME;
                end else begin
                    res_flags = FLAG_NONE;
                end
            end
            OP_PROMPT: begin
                res_kind = KIND_PROMPT;
                res_len  = '0;
                res_ovf  = 1'b0;
            end
            OP_STORE: begin
                res_len = '0;
                res_ovf = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_m_err    <= 1'b1;
            r_m_cont   <= 1'b1;
            r_m_saved  <= 1'b1;
            r_m_banner <= 1'b1;
            r_m_time   <= 1'b1;
            r_year     <= '0;
            for (int i = 0; i < NFIELD; i++) begin
                r_fact[i] <= 1'b0;
            end
            for (int i = 1; i < NFIELD; i++) begin
                r_tval[i] <= '0;
            end
            r_valid    <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_ovf      <= n_ovf;
            r_m_err    <= n_m_err;
            r_m_cont   <= n_m_cont;
            r_m_saved  <= n_m_saved;
            r_m_banner <= n_m_banner;
            r_m_time   <= n_m_time;
            r_year     <= n_year;
            r_fact     <= n_fact;
            r_tval     <= n_tval;
            if (out_load) begin
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        if (out_load) begin
            r_kind   <= res_kind;
            r_onehot <= res_onehot;
            r_len    <= res_len;
            r_flags  <= res_flags;
            r_o_ovf  <= res_ovf;
            r_o_year <= (res_flags == FLAG_TIME) ? r_year : '0;
            for (int i = 1; i < NFIELD; i++) begin
                r_o_tval[i] <= (res_flags == FLAG_TIME) ? r_tval[i] : '0;
            end
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.kind         = r_kind;
    assign o_res.code_onehot  = r_onehot;
    assign o_res.line_length  = r_len;
    assign o_res.reply_flags  = r_flags;
    assign o_res.year_value   = r_o_year;
    assign o_res.month_value  = r_o_tval[1];
    assign o_res.day_value    = r_o_tval[2];
    assign o_res.hour_value   = r_o_tval[3];
    assign o_res.minute_value = r_o_tval[4];
    assign o_res.second_value = r_o_tval[5];
    assign o_res.overflowed   = r_o_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LINE_STORE))
        else $error("line count beyond store");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == CNT_W'(LINE_STORE)))
        else $error("overflow flag set on a line that is not full");

    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_res.ready && i_q_valid && emits) |-> !o_pop)
        else $error("result overwritten while waiting");

    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_cmd.op == OP_CR || i_cmd.op == OP_LF)) |=> (r_count == '0 && !r_ovf))
        else $error("line state not cleared at line end");

endmodule

// ----- hdl/modem_response_line_classifier.sv -----
// Top level of the modem response line classifier.
//
//   channel  dir  payload
//   i_rx     in   rx_byte
//   o_res    out  kind, code_onehot, line_length, reply_flags, date/time fields, overflowed
//
// One byte is taken per cycle unless the queue is full; a byte is classified in the
// front end and queued, the back end updates the line state and registers a result.
// The output stalls only the back end; the four-entry queue keeps the input open
// until it fills. Reset is synchronous; no clearing pass is needed after it.
module modem_response_line_classifier import mrlc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mrlc_in_if.sink    i_rx,
    mrlc_out_if.source o_res
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_cmd push_cmd;
    t_cmd head_cmd;

    mrlc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (push_cmd)
    );

    mrlc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    mrlc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .o_pop     (q_pop),
        .o_res     (o_res)
    );

endmodule
